@@ hw/rtl/mqzs_pkg.sv @@
// ----------------------------------------------------------------------------
// mqzs_pkg
// Shared types and constants for the quadrant zero scan.
// ----------------------------------------------------------------------------
package mqzs_pkg;

	localparam int ROW_W      = 12;
	localparam int HGT_W      = 13;
	localparam int MAX_HEIGHT = 4096;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [3:0] QUAD_ALL = 4'hF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_PASS_PERIOD  = 2'd2
	} mqzs_reg_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mqzs_mul_req_t;

endpackage

@@ hw/rtl/mqzs_ram.sv @@
// ----------------------------------------------------------------------------
// mqzs_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mqzs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/mqzs_mul.sv @@
// ----------------------------------------------------------------------------
// mqzs_mul
// 64x64 unsigned multiplier built on one 32x32 multiplier, four partial
// products accumulated one after another.
// ----------------------------------------------------------------------------
module mqzs_mul (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mqzs_pkg::mqzs_mul_req_t req,
	output logic                   done,
	output logic [127:0]           product
);
	import mqzs_pkg::*;

	logic [63:0]  a_q, b_q;
	logic [2:0]   step_q;
	logic         busy_q, done_q, pv_s1;
	logic [1:0]   idx_s1;
	logic [63:0]  part_s1;
	logic [127:0] acc_q;
	logic [31:0]  op_a, op_b;
	logic [127:0] part_sh;

	always_comb begin
		op_a = step_q[1] ? a_q[63:32] : a_q[31:0];
		op_b = step_q[0] ? b_q[63:32] : b_q[31:0];
	end

	always_comb begin
		case (idx_s1)
			2'd0:    part_sh = {64'd0, part_s1};
			2'd3:    part_sh = {part_s1, 64'd0};
			default: part_sh = {32'd0, part_s1, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			pv_s1  <= (step_q != 3'd4);
			step_q <= step_q + 3'd1;
			busy_q <= (step_q != 3'd4);
			done_q <= (step_q == 3'd4);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			part_s1 <= op_a * op_b;
			idx_s1  <= step_q[1:0];
			if (pv_s1) begin
				acc_q <= acc_q + part_sh;
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ hw/rtl/mandelbrot_quadrant_zero_scan.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_quadrant_zero_scan
// One z*z+c step per pixel with a 3x3 quadrant/magnitude window kept in
// line stores; flags probable zeros at the lagging centre pixel.
// One item at a time: a new item is taken only once the last result is loaded;
// each item needs five 64x64 products on the shared 32x32 multiplier
// plus line store reads.
// Reset: counters to zero, registers to their defaults, output empty;
// line stores and window are not cleared.
// ----------------------------------------------------------------------------
module mandelbrot_quadrant_zero_scan #(
	parameter int MAX_WIDTH = 2048,
	parameter int FRAC_BITS = 60
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [mqzs_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mqzs_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [63:0]                     c_re,
	input  logic signed [63:0]                     c_im,
	input  logic signed [63:0]                     z_re,
	input  logic signed [63:0]                     z_im,
	input  logic                                   first_of_pass,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [63:0]                     next_z_re,
	output logic signed [63:0]                     next_z_im,
	output logic                                   zero_found,
	output logic [15:0]                            found_period,
	output logic signed [63:0]                     found_c_re,
	output logic signed [63:0]                     found_c_im,
	output logic [10:0]                            found_col,
	output logic [11:0]                            found_row
);
	import mqzs_pkg::*;

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int LAW = $clog2(2 * MAX_WIDTH);
	localparam int WW  = (CW + 1 > 12) ? CW + 1 : 12;
	localparam logic [127:0] BIAS_RE = 128'd1 << (FRAC_BITS - 1);
	localparam logic [127:0] BIAS_IM = 128'd1 << (FRAC_BITS - 2);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_RD0  = 13'b0000000000010,
		S_RD1  = 13'b0000000000100,
		S_RD2  = 13'b0000000001000,
		S_M1   = 13'b0000000010000,
		S_M2   = 13'b0000000100000,
		S_M3   = 13'b0000001000000,
		S_SUM  = 13'b0000010000000,
		S_RND  = 13'b0000100000000,
		S_SQ   = 13'b0001000000000,
		S_M4   = 13'b0010000000000,
		S_M5   = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} state_t;

	typedef struct packed {
		logic [3:0]  quad;
		logic [63:0] mag;
	} cell_t;

	state_t st_q, st_d;

	logic [11:0] width_q;
	logic [12:0] height_q;
	logic [15:0] period_q;
	logic [CW-1:0] column_count_q;
	logic [ROW_W-1:0] row_count_q;

	logic [CW-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic signed [63:0] cre_q, cim_q, zre_q, zim_q;
	logic [127:0] sq_re_q, sq_im_q, cross_q, sq_nre_q;
	logic signed [127:0] tre_q, tim_q;
	logic signed [63:0] nre_q, nim_q;
	cell_t old_q, prev_q;
	logic [127:0] pline_q, spare_q;
	cell_t win_q [9];

	logic out_valid_q, found_q;
	logic [63:0] onre_q, onim_q, fcre_q, fcim_q;
	logic [15:0] fper_q;
	logic [10:0] fcol_q;
	logic [11:0] frow_q;

	logic accept, do_load;
	logic [WW-1:0] wx, w_eff;
	logic [HGT_W-1:0] h_eff;
	logic [CW-1:0] col_a;
	logic [ROW_W-1:0] row_a;

	mqzs_mul_req_t mreq;
	logic mul_done;
	logic [127:0] mul_p;

	logic [LAW-1:0] slot_old, slot_prev, line_raddr;
	logic [67:0] line_rdata, param_dummy;
	logic [127:0] param_rdata;

	logic signed [127:0] cross_s, tre_d, tim_d, yre, yim;
	logic signed [63:0] nre_d, nim_d;
	logic [127:0] msum;
	cell_t new_cell;
	logic [3:0] qor;
	logic cen_le, eval, flag;
	logic [WW-1:0] col_m1;
	logic [ROW_W-1:0] row_m1;

	function automatic logic [63:0] absv(input logic [63:0] v);
		absv = v[63] ? (~v + 64'd1) : v;
	endfunction

	assign accept  = in_valid && st_q == S_IDLE;
	assign in_stall = (st_q != S_IDLE);
	assign do_load = (st_q == S_DONE) && (!out_valid_q || !out_stall);

	// effective frame size
	always_comb begin
		wx = WW'(width_q);
		if (wx < WW'(3)) begin
			w_eff = WW'(3);
		end else if (wx > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = wx;
		end
		if (height_q < 13'd3) begin
			h_eff = 13'd3;
		end else if (height_q > HGT_W'(MAX_HEIGHT)) begin
			h_eff = HGT_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		col_a = first_of_pass ? '0 : column_count_q;
		row_a = first_of_pass ? '0 : row_count_q;
	end

	// config and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q        <= 12'd1920;
			height_q       <= 13'd1080;
			period_q       <= 16'd1;
			column_count_q <= '0;
			row_count_q    <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= cfg_data[11:0];
					REG_IMAGE_HEIGHT: height_q <= cfg_data[12:0];
					REG_PASS_PERIOD:  period_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (WW'(col_a) + WW'(1) >= w_eff) begin
					column_count_q <= '0;
					if (HGT_W'(row_a) + HGT_W'(1) >= h_eff) begin
						row_count_q <= '0;
					end else begin
						row_count_q <= row_a + ROW_W'(1);
					end
				end else begin
					column_count_q <= col_a + CW'(1);
					row_count_q    <= row_a;
				end
			end
		end
	end

	// sequencer
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (accept) st_d = S_RD0;
			S_RD0:  st_d = S_RD1;
			S_RD1:  st_d = S_RD2;
			S_RD2:  st_d = S_M1;
			S_M1:   if (mul_done) st_d = S_M2;
			S_M2:   if (mul_done) st_d = S_M3;
			S_M3:   if (mul_done) st_d = S_SUM;
			S_SUM:  st_d = S_RND;
			S_RND:  st_d = S_SQ;
			S_SQ:   st_d = S_M4;
			S_M4:   if (mul_done) st_d = S_M5;
			S_M5:   if (mul_done) st_d = S_DONE;
			S_DONE: if (do_load) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// multiplier operand select
	always_comb begin
		mreq = '0;
		case (st_q)
			S_RD2: begin
				mreq = '{1'b1, absv(zre_q), absv(zre_q)};
			end
			S_M1: begin
				mreq = '{mul_done, absv(zim_q), absv(zim_q)};
			end
			S_M2: begin
				mreq = '{mul_done, absv(zre_q), absv(zim_q)};
			end
			S_SQ: begin
				mreq = '{1'b1, absv(nre_q), absv(nre_q)};
			end
			S_M4: begin
				mreq = '{mul_done, absv(nim_q), absv(nim_q)};
			end
			default: mreq = '0;
		endcase
	end

	mqzs_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.done    (mul_done),
		.product (mul_p)
	);

	// line stores
	assign slot_old  = row_q[0] ? LAW'(MAX_WIDTH) + LAW'(col_q) : LAW'(col_q);
	assign slot_prev = row_q[0] ? LAW'(col_q) : LAW'(MAX_WIDTH) + LAW'(col_q);
	assign line_raddr = (st_q == S_RD1) ? slot_prev : slot_old;

	mqzs_ram #(.WIDTH(68), .DEPTH(2 * MAX_WIDTH)) u_line_ram (
		.clk   (clk),
		.we    (do_load),
		.waddr (slot_old),
		.wdata (win_q[8]),
		.raddr (line_raddr),
		.rdata (line_rdata)
	);

	mqzs_ram #(.WIDTH(128), .DEPTH(MAX_WIDTH)) u_param_ram (
		.clk   (clk),
		.we    (do_load),
		.waddr (col_q),
		.wdata ({cre_q, cim_q}),
		.raddr (col_q),
		.rdata (param_rdata)
	);

	assign param_dummy = line_rdata;

	// arithmetic
	always_comb begin
		cross_s = (zre_q[63] ^ zim_q[63]) ? -$signed(cross_q) : $signed(cross_q);
		tre_d = $signed(sq_re_q - sq_im_q) + ($signed({{64{cre_q[63]}}, cre_q}) <<< FRAC_BITS);
		tim_d = cross_s + ($signed({{64{cim_q[63]}}, cim_q}) <<< (FRAC_BITS - 1));
		yre = $signed(tre_q + BIAS_RE) >>> FRAC_BITS;
		yim = $signed(tim_q + BIAS_IM) >>> (FRAC_BITS - 1);
		if ((&yre[127:63]) || !(|yre[127:63])) begin
			nre_d = yre[63:0];
		end else begin
			nre_d = yre[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		if ((&yim[127:63]) || !(|yim[127:63])) begin
			nim_d = yim[63:0];
		end else begin
			nim_d = yim[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		msum = sq_nre_q + mul_p;
		new_cell.quad = 4'd1 << {(!nim_q[63] && nim_q != 64'd0),
			(!nre_q[63] && nre_q != 64'd0)};
		new_cell.mag = (|msum[127:64+FRAC_BITS]) ? {64{1'b1}} :
			msum[FRAC_BITS+63:FRAC_BITS];
	end

	// window evaluation
	always_comb begin
		qor = '0;
		cen_le = 1'b1;
		for (int k = 0; k < 9; k++) begin
			qor = qor | win_q[k].quad;
			cen_le = cen_le && (win_q[4].mag <= win_q[k].mag);
		end
		eval = (col_q >= CW'(2)) && (row_q >= ROW_W'(2)) &&
			(WW'(col_q) < w_eff) && (HGT_W'(row_q) < h_eff);
		flag = eval && (qor == QUAD_ALL) && cen_le && (win_q[4].mag != {64{1'b1}});
		col_m1 = WW'(col_q) - WW'(1);
		row_m1 = row_q - ROW_W'(1);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= col_a;
			row_q <= row_a;
			cre_q <= c_re;
			cim_q <= c_im;
			zre_q <= z_re;
			zim_q <= z_im;
		end
		if (st_q == S_RD1) begin
			old_q   <= param_dummy;
			pline_q <= param_rdata;
		end
		if (st_q == S_RD2) prev_q <= line_rdata;
		if (st_q == S_M1 && mul_done) sq_re_q <= mul_p;
		if (st_q == S_M2 && mul_done) sq_im_q <= mul_p;
		if (st_q == S_M3 && mul_done) cross_q <= mul_p;
		if (st_q == S_SUM) begin
			tre_q <= tre_d;
			tim_q <= tim_d;
		end
		if (st_q == S_RND) begin
			nre_q <= nre_d;
			nim_q <= nim_d;
		end
		if (st_q == S_M4 && mul_done) sq_nre_q <= mul_p;
		if (st_q == S_M5 && mul_done) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= old_q;
			win_q[5] <= prev_q;
			win_q[8] <= new_cell;
		end
		if (do_load) begin
			spare_q <= pline_q;
			onre_q  <= nre_q;
			onim_q  <= nim_q;
			found_q <= flag;
			fper_q  <= flag ? period_q : 16'd0;
			fcre_q  <= flag ? spare_q[127:64] : 64'd0;
			fcim_q  <= flag ? spare_q[63:0] : 64'd0;
			fcol_q  <= flag ? col_m1[10:0] : 11'd0;
			frow_q  <= flag ? row_m1 : 12'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_z_re    = onre_q;
	assign next_z_im    = onim_q;
	assign zero_found   = found_q;
	assign found_period = fper_q;
	assign found_c_re   = fcre_q;
	assign found_c_im   = fcim_q;
	assign found_col    = fcol_q;
	assign found_row    = frow_q;

	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (st_q == S_M1 || st_q == S_M2 || st_q == S_M3 ||
			st_q == S_M4 || st_q == S_M5))
		else $error("multiplier done outside a wait state");

	a_found_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_found) |-> (found_row != 12'd0))
		else $error("zero found on the top row");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q == S_DONE))
		else $error("result loaded outside the done state");

endmodule
